// ===== design/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants of the cursor shape classifier: field widths,
// counter limits, register addresses and the class codes.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Fixed widths of the transaction fields
  localparam int ALPHA_W = 8;
  localparam int DIM_W   = 7;
  localparam int HOT_W   = 6;
  localparam int CLASS_W = 3;

  // Opaque counters saturate at all ones
  localparam int                 CNT_W   = 13;
  localparam logic [CNT_W-1:0]   CNT_MAX = '1;

  // Width of the area of a full-size image
  localparam int AREA_W = 2 * DIM_W;

  // Width of the ratio cross products (25 * 8191 and 7 * 127 * 127 fit)
  localparam int PROD_W = 20;

  // Fewer opaque pixels than this always classify as arrow
  localparam logic [CNT_W-1:0] MIN_OPAQUE = 13'd5;

  // Balance substitute when the right or bottom count is zero
  localparam logic [CNT_W-1:0] ZERO_BALANCE = 13'd10;

  // Configuration space
  localparam int                ADDR_W      = 3;
  localparam int                DATA_W      = 32;
  localparam logic [ADDR_W-1:0] ADDR_THRESH = 3'd0;
  localparam logic [ALPHA_W-1:0] THRESH_RESET = 8'd128;

  typedef enum logic [CLASS_W-1:0] {
    CLS_ARROW      = 3'd0,
    CLS_TEXT       = 3'd1,
    CLS_CROSS      = 3'd2,
    CLS_HAND       = 3'd3,
    CLS_MOVE       = 3'd4,
    CLS_VRESIZE    = 3'd5,
    CLS_HRESIZE    = 3'd6,
    CLS_NOTALLOWED = 3'd7
  } cls_e;

  // Counts and geometry captured at the end of one image
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [HOT_W-1:0]  hot_x;
    logic [HOT_W-1:0]  hot_y;
    logic [AREA_W-1:0] area;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  left;
    logic [CNT_W-1:0]  right;
    logic [CNT_W-1:0]  top;
    logic [CNT_W-1:0]  bottom;
    logic [CNT_W-1:0]  middle;
  } snap_t;

endpackage

// ===== design/cursor_shape_classifier.sv =====
// ----------------------------------------------------------------------------
// cursor_shape_classifier
// Counts opaque pixels of a raster-order cursor image by half and by middle
// column third, and emits one shape class per image after its last pixel.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+--------------------------
//  pixel    | in        | in_valid_i / in_ready_o      | pixel_alpha_i, image_width_i,
//           |           |                              | image_height_i, hotspot_x_i,
//           |           |                              | hotspot_y_i, last_pixel_i
//  class    | out       | out_valid_o / out_ready_i    | cursor_class_o
//  config   | in        | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
//  One pixel transaction per cycle while in_ready_o is high. Per pixel only the
//  position counters and six saturating opaque counters advance. A last pixel
//  copies the updated counts and the image area into a snapshot register and
//  clears the counters; the threshold rules are then evaluated from the
//  snapshot into the output register once that register is free.
//  Reset clears counters, valid flags and sets the alpha threshold to 128.
//  A stalled output holds the snapshot; pixels keep flowing until the
//  snapshot stage is also full, then in_ready_o drops.
//
module cursor_shape_classifier
  import csc_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ALPHA_W-1:0]  pixel_alpha_i,
  input  logic [DIM_W-1:0]    image_width_i,
  input  logic [DIM_W-1:0]    image_height_i,
  input  logic [HOT_W-1:0]    hotspot_x_i,
  input  logic [HOT_W-1:0]    hotspot_y_i,
  input  logic                last_pixel_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CLASS_W-1:0]  cursor_class_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // Largest size the 7-bit fields can reach after clamping
  localparam int DimCap = (MAX_DIM < 127) ? MAX_DIM : 127;
  // Position counters only ever hold values below the clamped size
  localparam int PW     = $clog2(DimCap);
  // Room for 3 * position + 3 and 2 * size
  localparam int CW     = DIM_W + 2;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [ALPHA_W-1:0] thresh_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_THRESH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_wr) begin
      thresh_q <= pwdata[ALPHA_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_THRESH) begin
      prdata = DATA_W'(thresh_q);
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: pixel -> snapshot -> output register
  // --------------------------------------------------------------------------
  logic  snap_valid_q, snap_valid_d;
  logic  out_valid_q, out_valid_d;
  logic  out_free, snap_free, in_fire, snap_fire;
  cls_e  class_q, class_d;
  snap_t snap_q, snap_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign snap_free  = !snap_valid_q || out_free;
  assign in_ready_o = snap_free;
  assign in_fire    = in_valid_i && in_ready_o;
  // Snapshot moves into the output register
  assign snap_fire  = snap_valid_q && out_free;

  // --------------------------------------------------------------------------
  // Per-pixel counting
  // --------------------------------------------------------------------------
  logic [PW-1:0]    col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] tot_q, tot_d, left_q, left_d, right_q, right_d;
  logic [CNT_W-1:0] top_q, top_d, bot_q, bot_d, mid_q, mid_d;

  logic [DIM_W-1:0] w_in, h_in;
  logic [PW-1:0]    x, y;
  logic [CW-1:0]    x_ext, y_ext, w_ext, h_ext;
  logic             size_ok, opaque, in_left, in_top, in_mid, col_wrap, row_wrap;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] cnt, logic en);
    sat_inc = (en && cnt != CNT_MAX) ? cnt + CNT_W'(1) : cnt;
  endfunction

  // Clamp oversized images to MAX_DIM
  assign w_in = (int'(image_width_i) > MAX_DIM) ? DIM_W'(MAX_DIM) : image_width_i;
  assign h_in = (int'(image_height_i) > MAX_DIM) ? DIM_W'(MAX_DIM) : image_height_i;

  always_comb begin
    size_ok = (w_in != '0) && (h_in != '0);
    // Restart the position when it no longer fits the current size
    x = (DIM_W'(col_q) >= w_in) ? '0 : col_q;
    y = (DIM_W'(row_q) >= h_in) ? '0 : row_q;
    x_ext = CW'(x);
    y_ext = CW'(y);
    w_ext = CW'(w_in);
    h_ext = CW'(h_in);

    opaque = pixel_alpha_i > thresh_q;
    // x < w/2, y < h/2 and w/3 <= x < 2w/3 with floor division, rewritten
    // as exact integer compares
    in_left = ((x_ext << 1) + CW'(2)) <= w_ext;
    in_top  = ((y_ext << 1) + CW'(2)) <= h_ext;
    in_mid  = (w_ext < ((x_ext << 1) + x_ext + CW'(3))) &&
              (((x_ext << 1) + x_ext + CW'(3)) <= (w_ext << 1));

    col_wrap = (x_ext + CW'(1)) >= w_ext;
    row_wrap = (y_ext + CW'(1)) >= h_ext;

    col_d   = col_q;
    row_d   = row_q;
    tot_d   = tot_q;
    left_d  = left_q;
    right_d = right_q;
    top_d   = top_q;
    bot_d   = bot_q;
    mid_d   = mid_q;

    if (size_ok) begin
      tot_d   = sat_inc(tot_q, opaque);
      left_d  = sat_inc(left_q, opaque && in_left);
      right_d = sat_inc(right_q, opaque && !in_left);
      top_d   = sat_inc(top_q, opaque && in_top);
      bot_d   = sat_inc(bot_q, opaque && !in_top);
      mid_d   = sat_inc(mid_q, opaque && in_mid);
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : y + PW'(1);
      end else begin
        col_d = x + PW'(1);
        row_d = y;
      end
    end
  end

  // Capture the updated counts at the end of an image
  always_comb begin
    snap_d.width  = w_in;
    snap_d.height = h_in;
    snap_d.hot_x  = hotspot_x_i;
    snap_d.hot_y  = hotspot_y_i;
    snap_d.area   = AREA_W'(w_in) * AREA_W'(h_in);
    snap_d.total  = tot_d;
    snap_d.left   = left_d;
    snap_d.right  = right_d;
    snap_d.top    = top_d;
    snap_d.bottom = bot_d;
    snap_d.middle = mid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      tot_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
      top_q   <= '0;
      bot_q   <= '0;
      mid_q   <= '0;
    end else if (in_fire) begin
      if (last_pixel_i) begin
        // Clear for the next image
        col_q   <= '0;
        row_q   <= '0;
        tot_q   <= '0;
        left_q  <= '0;
        right_q <= '0;
        top_q   <= '0;
        bot_q   <= '0;
        mid_q   <= '0;
      end else begin
        col_q   <= col_d;
        row_q   <= row_d;
        tot_q   <= tot_d;
        left_q  <= left_d;
        right_q <= right_d;
        top_q   <= top_d;
        bot_q   <= bot_d;
        mid_q   <= mid_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Classification from the snapshot
  // --------------------------------------------------------------------------
  always_comb begin
    logic [PROD_W-1:0] t, c, ln, rn, tn, bn, wh, w, h, hx, hy;
    logic              center, square, text, xhair, hand, move, vres, hres, noallow;

    t  = PROD_W'(snap_q.total);
    c  = PROD_W'(snap_q.middle);
    wh = PROD_W'(snap_q.area);
    w  = PROD_W'(snap_q.width);
    h  = PROD_W'(snap_q.height);
    hx = PROD_W'(snap_q.hot_x);
    hy = PROD_W'(snap_q.hot_y);

    // A zero right or bottom count means balance ten
    if (snap_q.right == '0) begin
      ln = PROD_W'(ZERO_BALANCE);
      rn = PROD_W'(1);
    end else begin
      ln = PROD_W'(snap_q.left);
      rn = PROD_W'(snap_q.right);
    end
    if (snap_q.bottom == '0) begin
      tn = PROD_W'(ZERO_BALANCE);
      bn = PROD_W'(1);
    end else begin
      tn = PROD_W'(snap_q.top);
      bn = PROD_W'(snap_q.bottom);
    end

    // Hotspot strictly inside the middle third both ways
    center = (PROD_W'(3) * hx > w) && (PROD_W'(3) * hx + PROD_W'(3) <= (w << 1)) &&
             (PROD_W'(3) * hy > h) && (PROD_W'(3) * hy + PROD_W'(3) <= (h << 1));
    // Aspect ratio between 0.8 and 1.2
    square = (PROD_W'(5) * w > PROD_W'(4) * h) && (PROD_W'(5) * w < PROD_W'(6) * h);

    text  = center && ((t << 2) < wh) && (PROD_W'(20) * c > PROD_W'(11) * t);
    xhair = square && center && (PROD_W'(25) * t < PROD_W'(3) * wh);
    hand  = (PROD_W'(3) * hy + PROD_W'(3) <= h) &&
            (PROD_W'(20) * t > PROD_W'(3) * wh) && (PROD_W'(5) * t < PROD_W'(3) * wh) &&
            ((ln << 1) > rn) && (ln < (rn << 1)) &&
            ((hx << 2) > w) && ((hx << 2) + PROD_W'(4) <= PROD_W'(3) * w);
    move  = square && center &&
            (PROD_W'(25) * t > (wh << 1)) && (PROD_W'(5) * t < (wh << 1)) &&
            (PROD_W'(5) * ln > PROD_W'(3) * rn) && ((ln << 1) < PROD_W'(3) * rn) &&
            (PROD_W'(5) * tn > PROD_W'(3) * bn) && ((tn << 1) < PROD_W'(3) * bn);
    vres  = (PROD_W'(10) * w < PROD_W'(7) * h) && center && (PROD_W'(10) * t > wh);
    hres  = (PROD_W'(5) * w > PROD_W'(7) * h) && center && (PROD_W'(10) * t > wh);
    noallow = square && center && (PROD_W'(10) * t > wh) &&
              (PROD_W'(20) * t < PROD_W'(7) * wh) && (PROD_W'(20) * c < PROD_W'(9) * t);

    // First matching rule wins
    if (snap_q.width == '0 || snap_q.height == '0 || snap_q.total < MIN_OPAQUE) begin
      class_d = CLS_ARROW;
    end else if (text) begin
      class_d = CLS_TEXT;
    end else if (xhair) begin
      class_d = CLS_CROSS;
    end else if (hand) begin
      class_d = CLS_HAND;
    end else if (move) begin
      class_d = CLS_MOVE;
    end else if (vres) begin
      class_d = CLS_VRESIZE;
    end else if (hres) begin
      class_d = CLS_HRESIZE;
    end else if (noallow) begin
      class_d = CLS_NOTALLOWED;
    end else begin
      class_d = CLS_ARROW;
    end
  end

  // --------------------------------------------------------------------------
  // Stage registers
  // --------------------------------------------------------------------------
  always_comb begin
    snap_valid_d = snap_valid_q;
    if (snap_free) begin
      snap_valid_d = in_fire && last_pixel_i;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = snap_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: load only on a moving transaction
  always_ff @(posedge clk_i) begin
    if (in_fire && last_pixel_i) begin
      snap_q <= snap_d;
    end
    if (snap_fire) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_class_o = class_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_pixel_i) |=> (col_q == '0 && row_q == '0 && tot_q == '0))
    else $error("counters not cleared after last pixel");

  a_total_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tot_q >= left_q) && (tot_q >= right_q) && (tot_q >= mid_q) &&
    (tot_q >= top_q) && (tot_q >= bot_q))
    else $error("partial opaque count exceeds total");

  a_few_opaque_arrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_fire && snap_q.total < MIN_OPAQUE) |=> (class_q == CLS_ARROW))
    else $error("sparse image not classified as arrow");

  a_out_from_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(snap_valid_q))
    else $error("result without a captured image");

endmodule
